// ===== sv/hsp_pkg.sv =====
// Shared types, constants and helpers for the header stream parser.
package hsp_pkg;

  localparam int HASH_BYTES_DEF  = 32;
  localparam int QUEUE_DEPTH_DEF = 2;
  localparam int MAGIC_W         = 32;
  localparam int VERSION_W       = 16;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_MAGIC   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VERSION = 2'd1;

  localparam logic [MAGIC_W-1:0]   MAGIC_RESET   = 32'h4842_4E44;
  localparam logic [VERSION_W-1:0] VERSION_RESET = 16'd1;

  typedef enum logic [3:0] {
    PH_MAGIC,
    PH_VERSION,
    PH_HEIGHT,
    PH_TIME,
    PH_PREV,
    PH_ROOT,
    PH_KEYLEN,
    PH_KEY,
    PH_SIGLEN,
    PH_SIG,
    PH_EXTRA
  } phase_t;

  typedef enum logic [2:0] {
    ST_PENDING,
    ST_OK,
    ST_TRUNC,
    ST_MAGIC,
    ST_VERSION,
    ST_KEY,
    ST_SIG,
    ST_TRAILING
  } status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_req_t;

  typedef struct packed {
    logic [3:0]  field_tag;
    logic [15:0] field_offset;
    logic [7:0]  byte_echo;
    logic [63:0] field_value;
    logic        field_complete;
    logic        frame_done;
    logic [2:0]  status;
  } out_res_t;

  typedef struct packed {
    phase_t      tag;
    logic [15:0] offset;
    logic [7:0]  data;
    logic        complete;
    logic        last;
    status_t     status;
  } item_t;

  function automatic logic is_int_phase(phase_t p);
    return p == PH_MAGIC || p == PH_VERSION || p == PH_HEIGHT ||
           p == PH_TIME || p == PH_KEYLEN || p == PH_SIGLEN;
  endfunction

endpackage

// ===== sv/hsp_front.sv =====
// Front end: accepts bytes, tracks fields, lengths and errors, builds queue items.
module hsp_front #(
  parameter int HASH_BYTES = hsp_pkg::HASH_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  hsp_pkg::in_req_t              in_data,
  input  logic [hsp_pkg::MAGIC_W-1:0]   expected_magic,
  input  logic [hsp_pkg::VERSION_W-1:0] expected_version,
  input  logic                          q_full,
  output logic                          q_push,
  output hsp_pkg::item_t                q_item
);
  import hsp_pkg::*;

  localparam int MIN_BYTES = 4 + 2 + 8 + 8 + 2 * HASH_BYTES + 2 + 2;
  localparam int SEEN_W    = $clog2(MIN_BYTES + 1);
  localparam logic [SEEN_W-1:0] MIN_CNT   = SEEN_W'(MIN_BYTES);
  localparam logic [15:0]       HASH_LAST = 16'(HASH_BYTES - 1);

  phase_t              phase, phase_next;
  logic [15:0]         field_count, field_count_next;
  logic [15:0]         length_left, length_left_next;
  logic [31:0]         facc, facc_next;
  logic [SEEN_W-1:0]   total_seen, total_seen_next;
  logic                magic_bad, magic_bad_next;
  logic                version_bad, version_bad_next;

  logic                accept;
  logic [7:0]          b;
  logic [31:0]         acc;
  logic [15:0]         last_off;
  logic                complete;
  phase_t              nph;
  logic [15:0]         ll;
  logic                mb, vb;
  logic [15:0]         fc;
  logic [SEEN_W-1:0]   seen;
  status_t             status;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign q_push   = accept;
  assign b        = in_data.data_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_MAGIC;
      field_count <= '0;
      length_left <= '0;
      facc        <= '0;
      total_seen  <= '0;
      magic_bad   <= 1'b0;
      version_bad <= 1'b0;
    end else begin
      phase       <= phase_next;
      field_count <= field_count_next;
      length_left <= length_left_next;
      facc        <= facc_next;
      total_seen  <= total_seen_next;
      magic_bad   <= magic_bad_next;
      version_bad <= version_bad_next;
    end
  end

  always_comb begin
    // narrow assembly: only magic, version and the two lengths are checked here
    acc = facc;
    if (field_count[15:2] == '0) begin
      unique case (field_count[1:0])
        2'd0: acc = {24'd0, b};
        2'd1: acc = facc | {16'd0, b, 8'd0};
        2'd2: acc = facc | {8'd0, b, 16'd0};
        2'd3: acc = facc | {b, 24'd0};
        default: acc = facc;
      endcase
    end

    unique case (phase)
      PH_MAGIC:                     last_off = 16'd3;
      PH_VERSION, PH_KEYLEN, PH_SIGLEN: last_off = 16'd1;
      PH_HEIGHT, PH_TIME:           last_off = 16'd7;
      PH_PREV, PH_ROOT:             last_off = HASH_LAST;
      default:                      last_off = 16'hFFFF;
    endcase

    if (phase == PH_KEY || phase == PH_SIG) begin
      complete = length_left <= 16'd1;
    end else if (phase != PH_EXTRA) begin
      complete = field_count >= last_off;
    end else begin
      complete = 1'b0;
    end

    seen = (total_seen < MIN_CNT) ? total_seen + 1'b1 : total_seen;

    nph = phase;
    ll  = length_left;
    mb  = magic_bad;
    vb  = version_bad;
    if (complete) begin
      unique case (phase)
        PH_MAGIC: begin
          mb  = acc != expected_magic;
          nph = PH_VERSION;
        end
        PH_VERSION: begin
          vb  = acc[15:0] != expected_version;
          nph = PH_HEIGHT;
        end
        PH_HEIGHT: nph = PH_TIME;
        PH_TIME:   nph = PH_PREV;
        PH_PREV:   nph = PH_ROOT;
        PH_ROOT:   nph = PH_KEYLEN;
        PH_KEYLEN: begin
          ll  = acc[15:0];
          nph = (acc[15:0] == '0) ? PH_SIGLEN : PH_KEY;
        end
        PH_KEY:    nph = PH_SIGLEN;
        PH_SIGLEN: begin
          ll  = acc[15:0];
          nph = (acc[15:0] == '0) ? PH_EXTRA : PH_SIG;
        end
        PH_SIG: begin
          ll  = '0;
          nph = PH_EXTRA;
        end
        default:   nph = PH_EXTRA;
      endcase
      fc = '0;
    end else begin
      fc = (field_count != 16'hFFFF) ? field_count + 16'd1 : field_count;
      if ((phase == PH_KEY || phase == PH_SIG) && length_left != '0) begin
        ll = length_left - 16'd1;
      end
    end

    status = ST_PENDING;
    if (in_data.last_byte) begin
      priority if (seen < MIN_CNT)     status = ST_TRUNC;
      else if (mb)                     status = ST_MAGIC;
      else if (vb)                     status = ST_VERSION;
      else if (nph <= PH_KEY)          status = ST_KEY;
      else if (nph == PH_SIGLEN || nph == PH_SIG) status = ST_SIG;
      else if (phase == PH_EXTRA)      status = ST_TRAILING;
      else                             status = ST_OK;
    end

    phase_next       = phase;
    field_count_next = field_count;
    length_left_next = length_left;
    facc_next        = facc;
    total_seen_next  = total_seen;
    magic_bad_next   = magic_bad;
    version_bad_next = version_bad;
    if (accept) begin
      if (in_data.last_byte) begin
        phase_next       = PH_MAGIC;
        field_count_next = '0;
        length_left_next = '0;
        facc_next        = '0;
        total_seen_next  = '0;
        magic_bad_next   = 1'b0;
        version_bad_next = 1'b0;
      end else begin
        phase_next       = nph;
        field_count_next = fc;
        length_left_next = ll;
        facc_next        = complete ? '0 : acc;
        total_seen_next  = seen;
        magic_bad_next   = mb;
        version_bad_next = vb;
      end
    end

    q_item.tag      = phase;
    q_item.offset   = field_count;
    q_item.data     = b;
    q_item.complete = complete;
    q_item.last     = in_data.last_byte;
    q_item.status   = status;
  end

endmodule

// ===== sv/hsp_queue.sv =====
// Short FIFO of classified bytes between front and back ends.
module hsp_queue #(
  parameter int DEPTH = hsp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  hsp_pkg::item_t push_item,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output hsp_pkg::item_t head_item
);
  import hsp_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  item_t             slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr, rd_ptr;
  logic [CNT_W-1:0]  count;

  assign full      = count == CNT_FULL;
  assign empty     = count == '0;
  assign head_item = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

// ===== sv/hsp_back.sv =====
// Back end: assembles little-endian field values and holds the output register.
module hsp_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_empty,
  input  hsp_pkg::item_t    q_item,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output hsp_pkg::out_res_t out_data
);
  import hsp_pkg::*;

  logic [63:0] bacc;
  logic [63:0] acc;
  logic        is_int;
  logic        load;

  assign load  = !q_empty && (!out_valid || out_ready);
  assign q_pop = load;

  always_comb begin
    is_int = is_int_phase(q_item.tag);
    if (q_item.offset == '0) begin
      acc = {56'd0, q_item.data};
    end else if (q_item.offset < 16'd8) begin
      acc = bacc | (64'(q_item.data) << {q_item.offset[2:0], 3'b000});
    end else begin
      acc = bacc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      bacc      <= '0;
    end else if (load) begin
      out_valid <= 1'b1;
      bacc      <= (q_item.complete || q_item.last || !is_int) ? '0 : acc;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data.field_tag      <= q_item.tag;
      out_data.field_offset   <= q_item.offset;
      out_data.byte_echo      <= q_item.data;
      out_data.field_value    <= is_int ? acc : '0;
      out_data.field_complete <= q_item.complete;
      out_data.frame_done     <= q_item.last;
      out_data.status         <= q_item.status;
    end
  end

endmodule

// ===== sv/header_stream_parser.sv =====
// Top level of the header stream parser: config registers, front, queue, back.
//
//   channel   direction  handshake             payload
//   in        input      in_valid / in_ready   in_data   (data_byte, last_byte)
//   out       output     out_valid / out_ready out_data  (tag, offset, value, status)
//   cfg       input      cfg_we                cfg_idx, cfg_wdata
//
// One byte per cycle sustained while out_ready stays high; an accepted byte is
// written to a queue slot at the accepting edge and loaded into the output
// register once it is at the queue head and the output register is free.
// The front state update is a registered loop on phase, counts and lengths.
// Reset is synchronous; config returns to its defaults, no clearing pass.
// in_ready drops only while the queue is full; a stalled output fills the queue.
module header_stream_parser #(
  parameter int HASH_BYTES  = hsp_pkg::HASH_BYTES_DEF,
  parameter int QUEUE_DEPTH = hsp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  hsp_pkg::in_req_t               in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output hsp_pkg::out_res_t              out_data,
  input  logic                           cfg_we,
  input  logic [hsp_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [hsp_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import hsp_pkg::*;

  logic [MAGIC_W-1:0]   expected_magic;
  logic [VERSION_W-1:0] expected_version;
  logic                 q_full, q_push, q_empty, q_pop;
  item_t                q_in, q_head;

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_magic   <= MAGIC_RESET;
      expected_version <= VERSION_RESET;
    end else if (cfg_we) begin
      if (cfg_idx == CFG_MAGIC) begin
        expected_magic <= cfg_wdata[MAGIC_W-1:0];
      end else if (cfg_idx == CFG_VERSION) begin
        expected_version <= cfg_wdata[VERSION_W-1:0];
      end
    end
  end

  hsp_front #(.HASH_BYTES(HASH_BYTES)) u_front (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data          (in_data),
    .expected_magic   (expected_magic),
    .expected_version (expected_version),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_item           (q_in)
  );

  hsp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head_item (q_head)
  );

  hsp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_item    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  a_done_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.frame_done == (out_data.status != 3'(ST_PENDING))))
    else $error("status and frame_done disagree");

  a_extra_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.field_tag == 4'(PH_EXTRA)
      |-> !out_data.field_complete && out_data.field_value == '0)
    else $error("extra byte carries value or completion");

  a_first_byte: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.field_offset == '0 &&
      (out_data.field_tag == 4'(PH_MAGIC) || out_data.field_tag == 4'(PH_HEIGHT))
      |-> out_data.field_value == {56'd0, out_data.byte_echo})
    else $error("first byte of integer field not assembled from zero");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push && !q_pop |-> !q_full)
    else $error("queue written while full");

endmodule

// ===== tb/header_stream_parser_tb.sv =====
// Testbench for header_stream_parser: byte-stream headers with a self-checking parser model.
`timescale 1ns / 1ps

module header_stream_parser_tb;
  import hsp_pkg::*;

  localparam int MIN_BYTES   = 4 + 2 + 8 + 8 + 2 * HASH_BYTES_DEF + 2 + 2;
  localparam int CYCLE_LIMIT = 800000;
  localparam int PHASE_BYTES = 40;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  localparam int FILL_RAND = 0;
  localparam int FILL_ZERO = 1;
  localparam int FILL_ONES = 2;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_req_t               in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_res_t              out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  header_stream_parser u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  always #6 clk = ~clk;

  // parser model state and register copies
  logic [MAGIC_W-1:0]   reg_magic = MAGIC_RESET;
  logic [VERSION_W-1:0] reg_version = VERSION_RESET;
  phase_t               hdr_phase = PH_MAGIC;
  logic [15:0]          hdr_count = '0;
  logic [15:0]          hdr_left = '0;
  logic [63:0]          hdr_accum = '0;
  int                   hdr_seen = 0;
  logic                 hdr_magic_bad = 1'b0;
  logic                 hdr_version_bad = 1'b0;

  in_req_t     byte_q[$];
  out_res_t    result_q[$];
  logic [7:0]  frame_buf[$];
  int          queued_bytes = 0;
  int          errors = 0;
  int unsigned cycles = 0;
  bit          in_took = 1'b0;
  int          send_gap = 0;
  int          stall_left = 0;

  wire calm = (cycles[9:8] == 2'b11);

  function automatic out_res_t parse_byte(in_req_t r);
    phase_t      p;
    phase_t      nxt;
    logic [15:0] off;
    logic [63:0] acc;
    logic        complete;
    logic        is_int;
    status_t     st;
    out_res_t    res;
    p = hdr_phase;
    off = hdr_count;
    acc = '0;
    nxt = p;
    st = ST_PENDING;
    is_int = p == PH_MAGIC || p == PH_VERSION || p == PH_HEIGHT ||
             p == PH_TIME || p == PH_KEYLEN || p == PH_SIGLEN;
    if (is_int) begin
      if (off == 0) acc = 64'(r.data_byte);
      else if (off < 8) acc = hdr_accum | (64'(r.data_byte) << (8 * off));
      else acc = hdr_accum;
    end
    case (p)
      PH_MAGIC: complete = off >= 3;
      PH_VERSION, PH_KEYLEN, PH_SIGLEN: complete = off >= 1;
      PH_HEIGHT, PH_TIME: complete = off >= 7;
      PH_PREV, PH_ROOT: complete = off >= HASH_BYTES_DEF - 1;
      PH_KEY, PH_SIG: complete = hdr_left <= 1;
      default: complete = 1'b0;
    endcase
    if (hdr_seen < MIN_BYTES) hdr_seen++;
    if (complete) begin
      case (p)
        PH_MAGIC: begin
          hdr_magic_bad = acc[31:0] != reg_magic;
          nxt = PH_VERSION;
        end
        PH_VERSION: begin
          hdr_version_bad = acc[15:0] != reg_version;
          nxt = PH_HEIGHT;
        end
        PH_KEYLEN: begin
          hdr_left = acc[15:0];
          nxt = hdr_left == 0 ? PH_SIGLEN : PH_KEY;
        end
        PH_KEY: nxt = PH_SIGLEN;
        PH_SIGLEN: begin
          hdr_left = acc[15:0];
          nxt = hdr_left == 0 ? PH_EXTRA : PH_SIG;
        end
        PH_SIG: begin
          hdr_left = '0;
          nxt = PH_EXTRA;
        end
        default: nxt = phase_t'(p + 1);
      endcase
      hdr_count = '0;
      hdr_accum = '0;
    end else begin
      if (hdr_count != 16'hFFFF) hdr_count++;
      if ((p == PH_KEY || p == PH_SIG) && hdr_left != 0) hdr_left--;
      hdr_accum = acc;
    end
    hdr_phase = nxt;
    if (r.last_byte) begin
      if (hdr_seen < MIN_BYTES) st = ST_TRUNC;
      else if (hdr_magic_bad) st = ST_MAGIC;
      else if (hdr_version_bad) st = ST_VERSION;
      else if (nxt == PH_KEY || nxt == PH_KEYLEN || nxt < PH_KEYLEN) st = ST_KEY;
      else if (nxt == PH_SIGLEN || nxt == PH_SIG) st = ST_SIG;
      else if (p == PH_EXTRA) st = ST_TRAILING;
      else st = ST_OK;
    end
    res.field_tag = p;
    res.field_offset = off;
    res.byte_echo = r.data_byte;
    res.field_value = is_int ? acc : '0;
    res.field_complete = complete;
    res.frame_done = r.last_byte;
    res.status = st;
    if (r.last_byte) begin
      hdr_phase = PH_MAGIC;
      hdr_count = '0;
      hdr_left = '0;
      hdr_accum = '0;
      hdr_seen = 0;
      hdr_magic_bad = 1'b0;
      hdr_version_bad = 1'b0;
    end
    return res;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return 0;
    if (r < 90) return $urandom_range(1, 12);
    if (r < 98) return $urandom_range(13, 64);
    return $urandom_range(65, 400);
  endfunction

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      errors++;
    end
  endtask

  // request driver
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_took) begin
    end else if (send_gap != 0 && !calm) begin
      in_valid <= 1'b0;
      send_gap--;
    end else if (byte_q.size() != 0) begin
      in_data <= byte_q.pop_front();
      in_valid <= 1'b1;
      send_gap = pick_gap();
    end else begin
      in_valid <= 1'b0;
    end
    in_took = 1'b0;
  end

  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (calm) begin
      out_ready <= 1'b1;
    end else if (stall_left != 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready <= 1'b1;
      stall_left = pick_gap();
    end
  end

  always @(posedge clk) begin : mon
    out_res_t want;
    if (!rst && in_valid && in_ready) begin
      result_q.insert(result_q.size(), parse_byte(in_data));
      in_took = 1'b1;
    end
    if (!rst && out_valid && out_ready) begin
      if (result_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %0h", $time, out_data);
        errors++;
      end else begin
        want = result_q.pop_front();
        check_field("field_tag", 64'(want.field_tag), 64'(out_data.field_tag));
        check_field("field_offset", 64'(want.field_offset), 64'(out_data.field_offset));
        check_field("byte_echo", 64'(want.byte_echo), 64'(out_data.byte_echo));
        check_field("field_value", want.field_value, out_data.field_value);
        check_field("field_complete", 64'(want.field_complete),
                    64'(out_data.field_complete));
        check_field("frame_done", 64'(want.frame_done), 64'(out_data.frame_done));
        check_field("status", 64'(want.status), 64'(out_data.status));
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic wait_idle();
    do @(negedge clk); while (byte_q.size() != 0 || in_valid || result_q.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= data;
    case (idx)
      CFG_MAGIC: reg_magic = data[MAGIC_W-1:0];
      CFG_VERSION: reg_version = data[VERSION_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_regs(input logic [MAGIC_W-1:0] mg, input logic [VERSION_W-1:0] ver);
    wait_idle();
    write_reg(CFG_MAGIC, mg);
    write_reg(CFG_SPARE_A, $urandom);
    write_reg(CFG_VERSION, CFG_DATA_W'(ver));
    write_reg(CFG_SPARE_B, $urandom);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic add_int(input logic [63:0] v, input int n);
    for (int i = 0; i < n; i++) frame_buf.insert(frame_buf.size(), v[8*i +: 8]);
  endtask

  task automatic add_fill(input int n, input int fill);
    for (int i = 0; i < n; i++)
      frame_buf.insert(frame_buf.size(),
                       fill == FILL_ZERO ? 8'h00 : fill == FILL_ONES ? 8'hFF : 8'($urandom));
  endtask

  task automatic make_header(input logic [31:0] mg, input logic [15:0] ver,
                             input logic [15:0] klen, input logic [15:0] slen, input int fill);
    frame_buf.delete();
    add_int(64'(mg), 4);
    add_int(64'(ver), 2);
    add_fill(16 + 2 * HASH_BYTES_DEF, fill);
    add_int(64'(klen), 2);
    add_fill(klen, fill);
    add_int(64'(slen), 2);
    add_fill(slen, fill);
  endtask

  // keep > 0 cuts the frame to its first keep bytes
  task automatic send_frame(input int keep, input int extra);
    in_req_t r;
    int      n;
    repeat (extra) frame_buf.insert(frame_buf.size(), 8'($urandom));
    n = (keep > 0 && keep < frame_buf.size()) ? keep : frame_buf.size();
    for (int i = 0; i < n; i++) begin
      r.data_byte = frame_buf[i];
      r.last_byte = (i == n - 1);
      byte_q.insert(byte_q.size(), r);
    end
    queued_bytes += n;
  endtask

  task automatic random_frames();
    int          start;
    int          shape;
    logic [31:0] mg;
    logic [15:0] ver;
    start = queued_bytes;
    while (queued_bytes - start < PHASE_BYTES) begin
      mg = reg_magic;
      ver = reg_version;
      if ($urandom_range(0, 99) < 10) mg ^= 32'd1 << $urandom_range(0, 31);
      if ($urandom_range(0, 99) < 10) ver ^= 16'd1 << $urandom_range(0, 15);
      make_header(mg, ver, 16'(pick_len()), 16'(pick_len()), FILL_RAND);
      shape = $urandom_range(0, 99);
      if (shape < 15) begin
        send_frame($urandom_range(1, frame_buf.size() - 1), 0);
      end else if (shape < 25) begin
        send_frame(0, $urandom_range(1, 6));
      end else if (shape < 32) begin
        frame_buf.delete();
        add_fill($urandom_range(1, 120), FILL_RAND);
        send_frame(0, 0);
      end else begin
        send_frame(0, 0);
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    make_header(reg_magic, reg_version, 16'd3, 16'd4, FILL_RAND);
    send_frame(0, 0);
    make_header(reg_magic, reg_version, 16'd0, 16'd0, FILL_ZERO);
    send_frame(0, 0);
    make_header(reg_magic, reg_version, 16'd0, 16'd2, FILL_ONES);
    send_frame(0, 0);
    make_header(reg_magic, reg_version, 16'd2, 16'd0, FILL_RAND);
    send_frame(0, 0);
    make_header(reg_magic ^ 32'h8000_0000, reg_version, 16'd1, 16'd1, FILL_RAND);
    send_frame(0, 0);
    make_header(reg_magic, reg_version ^ 16'h8000, 16'd1, 16'd1, FILL_RAND);
    send_frame(0, 0);
    make_header(~reg_magic, ~reg_version, 16'd0, 16'd0, FILL_ONES);
    send_frame(0, 0);
    frame_buf.delete();
    frame_buf.insert(frame_buf.size(), 8'hFF);
    send_frame(0, 0);
    make_header(reg_magic, reg_version, 16'd0, 16'd0, FILL_RAND);
    send_frame(MIN_BYTES - 1, 0);
    make_header(reg_magic, reg_version, 16'd1, 16'd0, FILL_RAND);
    send_frame(MIN_BYTES, 0);
    make_header(reg_magic, reg_version, 16'hFFFF, 16'd0, FILL_RAND);
    send_frame(96, 0);
    make_header(reg_magic, reg_version, 16'd0, 16'hFFFF, FILL_RAND);
    send_frame(96, 0);
    make_header(reg_magic, reg_version, 16'd5, 16'd5, FILL_RAND);
    send_frame(0, 4);
    make_header(reg_magic ^ 32'd1, reg_version, 16'd5, 16'd5, FILL_RAND);
    send_frame(88, 0);
    frame_buf.delete();
    add_fill(MIN_BYTES, FILL_RAND);
    send_frame(0, 0);

    random_frames();
    set_regs('0, '0);
    random_frames();
    set_regs('1, '1);
    random_frames();
    set_regs($urandom, 16'($urandom_range(0, 65535)));
    random_frames();
    set_regs(MAGIC_RESET, VERSION_RESET);
    random_frames();

    wait_idle();
    repeat (10) @(posedge clk);
    if (errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
